### rtl/swbl_pkg.sv
// Shared types, constants and symbol helpers for the single-wire backlight sender.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package swbl_pkg;

  localparam int LEVEL_BITS = 5;
  localparam int TIMER_BITS = 13;
  localparam int CFG_W      = 12;
  localparam int POS_BITS   = 5;

  // Address byte, end mark, three fixed bits, the level, then the closing end mark.
  localparam logic [POS_BITS-1:0] SYM_COUNT = POS_BITS'(13 + LEVEL_BITS);

  // Wire reset sequence lengths in ticks.
  localparam logic [TIMER_BITS-1:0] RST_LOW_A = TIMER_BITS'(4000);
  localparam logic [TIMER_BITS-1:0] RST_REL_A = TIMER_BITS'(120);
  localparam logic [TIMER_BITS-1:0] RST_LOW_B = TIMER_BITS'(500);
  localparam logic [TIMER_BITS-1:0] RST_REL_B = TIMER_BITS'(5);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SYM_LOW = 4'd1,
    PH_SYM_REL = 4'd2,
    PH_ACK     = 4'd3,
    PH_GAP     = 4'd4,
    PH_RLOW1   = 4'd5,
    PH_RREL1   = 4'd6,
    PH_RLOW2   = 4'd7,
    PH_RREL2   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    MODE_REL  = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_HIGH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_END  = 2'd2
  } sym_e;

  typedef enum logic [2:0] {
    CFG_DEV_ADDR    = 3'd0,
    CFG_SHORT_TIME  = 3'd1,
    CFG_EXTRA_TIME  = 3'd2,
    CFG_ACK_DELAY   = 3'd3,
    CFG_FRAME_GAP   = 3'd4,
    CFG_RETRY_LIMIT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                  req_type;
    logic [LEVEL_BITS-1:0] level;
    logic                  line_in;
  } swbl_in_t;

  typedef struct packed {
    logic [1:0] line_mode;
    logic       busy_res;
    logic       acked;
    logic [2:0] failures;
  } swbl_out_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [7:0]  short_time;
    logic [7:0]  extra_time;
    logic [7:0]  ack_delay;
    logic [11:0] frame_gap;
    logic [2:0]  retry_limit;
  } cfg_t;

  // Kind of the symbol sent at a given frame position.
  function automatic sym_e symbol_kind(input logic [POS_BITS-1:0]   pos,
                                       input logic [7:0]            addr,
                                       input logic [LEVEL_BITS-1:0] lvl);
    sym_e kind;
    if (pos < POS_BITS'(8)) begin
      kind = addr[3'(7 - int'(pos))] ? SYM_ONE : SYM_ZERO;
    end else if (pos == POS_BITS'(8)) begin
      kind = SYM_END;
    end else if (pos == POS_BITS'(9)) begin
      kind = SYM_ONE;
    end else if (pos < POS_BITS'(12)) begin
      kind = SYM_ZERO;
    end else if (pos < SYM_COUNT - POS_BITS'(1)) begin
      kind = lvl[3'(LEVEL_BITS - 1 - (int'(pos) - 12))] ? SYM_ONE : SYM_ZERO;
    end else begin
      kind = SYM_END;
    end
    return kind;
  endfunction

  // Phase length: base time, plus the extra time when the flag is set.
  function automatic logic [TIMER_BITS-1:0] phase_len(input logic [7:0] short_t,
                                                      input logic [7:0] extra_t,
                                                      input logic       add_extra);
    logic [8:0] base;
    logic [8:0] sum;
    base = (short_t == 8'd0) ? 9'd1 : {1'b0, short_t};
    sum  = base + (add_extra ? {1'b0, extra_t} : 9'd0);
    return TIMER_BITS'(sum);
  endfunction

endpackage

### rtl/swbl_core.sv
// Frame sequencer: phase state, timer and retry logic, one tick per accepted request.
// Depends on swbl_pkg for types, phase codes and symbol helpers.
`timescale 1ns / 1ps

module swbl_core import swbl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  swbl_in_t  req_i,
  input  cfg_t      cfg_i,
  output swbl_out_t rslt_o
);

  phase_e                ph_q, ph_d;
  logic [TIMER_BITS-1:0] tmr_q, tmr_d;
  logic [POS_BITS-1:0]   bp_q, bp_d;
  logic [2:0]            fail_q, fail_d;
  logic [LEVEL_BITS-1:0] lvl_q, lvl_d;
  mode_e                 mode_q, mode_d;

  logic                  ack;
  logic                  chk_ack;
  logic                  chk_gap;
  logic                  sym_go;
  logic [POS_BITS-1:0]   sym_pos;
  logic [POS_BITS-1:0]   nxt_bp;
  logic [TIMER_BITS-1:0] tmr_dec;
  sym_e                  cur_kind;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      tmr_q  <= '0;
      bp_q   <= '0;
      fail_q <= '0;
      lvl_q  <= '0;
      mode_q <= MODE_REL;
    end else if (accept_i) begin
      ph_q   <= ph_d;
      tmr_q  <= tmr_d;
      bp_q   <= bp_d;
      fail_q <= fail_d;
      lvl_q  <= lvl_d;
      mode_q <= mode_d;
    end
  end

  assign cur_kind = symbol_kind(bp_q, cfg_i.device_address, lvl_q);
  assign nxt_bp   = bp_q + POS_BITS'(1);
  assign tmr_dec  = (tmr_q != '0) ? tmr_q - TIMER_BITS'(1) : tmr_q;

  // Next state. A phase that ends on this tick hands over at once; a zero-length
  // acknowledge wait or gap is passed in the same tick, so up to three hand-overs chain.
  always_comb begin
    ph_d    = ph_q;
    tmr_d   = tmr_q;
    bp_d    = bp_q;
    fail_d  = fail_q;
    lvl_d   = lvl_q;
    mode_d  = mode_q;
    ack     = 1'b0;
    chk_ack = 1'b0;
    chk_gap = 1'b0;
    sym_go  = 1'b0;
    sym_pos = '0;

    if (req_i.req_type) begin
      // Start request: new level, fresh failure count, first symbol.
      lvl_d  = req_i.level;
      fail_d = '0;
      sym_go = 1'b1;
    end else if (ph_q != PH_IDLE) begin
      tmr_d = tmr_dec;
      if (tmr_dec == '0) begin
        unique case (ph_q)
          PH_SYM_LOW: begin
            ph_d   = PH_SYM_REL;
            tmr_d  = phase_len(cfg_i.short_time, cfg_i.extra_time, cur_kind == SYM_ONE);
            mode_d = MODE_REL;
          end
          PH_SYM_REL: begin
            bp_d = nxt_bp;
            if (nxt_bp < SYM_COUNT) begin
              sym_go  = 1'b1;
              sym_pos = nxt_bp;
            end else begin
              ph_d    = PH_ACK;
              tmr_d   = TIMER_BITS'(cfg_i.ack_delay);
              mode_d  = MODE_REL;
              chk_ack = (cfg_i.ack_delay == 8'd0);
            end
          end
          PH_ACK: chk_ack = 1'b1;
          PH_GAP: chk_gap = 1'b1;
          PH_RLOW1: begin
            ph_d   = PH_RREL1;
            tmr_d  = RST_REL_A;
            mode_d = MODE_REL;
          end
          PH_RREL1: begin
            ph_d   = PH_RLOW2;
            tmr_d  = RST_LOW_B;
            mode_d = MODE_LOW;
          end
          PH_RLOW2: begin
            ph_d   = PH_RREL2;
            tmr_d  = RST_REL_B;
            mode_d = MODE_REL;
          end
          PH_RREL2: sym_go = 1'b1;
          default: begin
            ph_d  = PH_IDLE;
            tmr_d = '0;
          end
        endcase
      end
    end

    // Acknowledge sampling at the end of the wait after a frame.
    if (chk_ack) begin
      if (!req_i.line_in) begin
        ack    = 1'b1;
        ph_d   = PH_IDLE;
        tmr_d  = '0;
        mode_d = MODE_HIGH;
      end else begin
        if (fail_d != 3'd7) begin
          fail_d = fail_d + 3'd1;
        end
        ph_d    = PH_GAP;
        tmr_d   = TIMER_BITS'(cfg_i.frame_gap);
        mode_d  = MODE_REL;
        chk_gap = (cfg_i.frame_gap == 12'd0);
      end
    end

    // End of the gap: resend, after the wire reset sequence once failures pile up.
    if (chk_gap) begin
      if (fail_d >= cfg_i.retry_limit) begin
        ph_d   = PH_RLOW1;
        tmr_d  = RST_LOW_A;
        mode_d = MODE_LOW;
      end else begin
        sym_go = 1'b1;
      end
    end

    // Begin the low phase of a symbol; the low half is long only for a zero bit.
    if (sym_go) begin
      bp_d   = sym_pos;
      ph_d   = PH_SYM_LOW;
      tmr_d  = phase_len(cfg_i.short_time, cfg_i.extra_time,
                         symbol_kind(sym_pos, cfg_i.device_address, lvl_d) == SYM_ZERO);
      mode_d = MODE_LOW;
    end
  end

  // Result of this tick.
  assign rslt_o.line_mode = mode_d;
  assign rslt_o.busy_res  = (ph_d != PH_IDLE);
  assign rslt_o.acked     = ack;
  assign rslt_o.failures  = fail_d;

  // A start request always opens a frame at its first symbol.
  a_start_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && req_i.req_type |=> ph_q == PH_SYM_LOW && bp_q == '0)
    else $error("start request did not open a frame");

  // Within a request the failure count never drops.
  a_fail_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !req_i.req_type |=> fail_q >= $past(fail_q))
    else $error("failure count decreased without a start request");

  // A tick while idle leaves the wire mode alone.
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !req_i.req_type && ph_q == PH_IDLE |=> mode_q == $past(mode_q))
    else $error("idle tick changed the line mode");

  // Frame position never runs past the acknowledge slot.
  a_bp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp_q <= SYM_COUNT)
    else $error("symbol position out of range");

endmodule

### rtl/single_wire_backlight_sender.sv
// Top level of the single-wire backlight sender: configuration registers, request
// handshake and result register. Depends on swbl_pkg and swbl_core.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Payload
//  in        request    in_valid_i / in_ready_o  in_data_i  (swbl_in_t)
//  out       result     out_valid_o / out_ready_i out_data_o (swbl_out_t)
//  cfg       write      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
//  One request per clock: the whole tick is worked out combinationally between the
//  phase registers and the result register, and its result shows the next cycle.
//  The request side stalls only while a result is held and the output is stalled.
//  Reset puts the sequencer idle with the wire released and loads default settings.

module single_wire_backlight_sender import swbl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  swbl_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output swbl_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  logic      out_valid_q;
  swbl_out_t out_data_q;
  swbl_out_t rslt;
  logic      accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= 8'd88;
      cfg_q.short_time     <= 8'd40;
      cfg_q.extra_time     <= 8'd50;
      cfg_q.ack_delay      <= 8'd10;
      cfg_q.frame_gap      <= 12'd900;
      cfg_q.retry_limit    <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEV_ADDR:    cfg_q.device_address <= cfg_wdata_i[7:0];
        CFG_SHORT_TIME:  cfg_q.short_time     <= cfg_wdata_i[7:0];
        CFG_EXTRA_TIME:  cfg_q.extra_time     <= cfg_wdata_i[7:0];
        CFG_ACK_DELAY:   cfg_q.ack_delay      <= cfg_wdata_i[7:0];
        CFG_FRAME_GAP:   cfg_q.frame_gap      <= cfg_wdata_i[11:0];
        CFG_RETRY_LIMIT: cfg_q.retry_limit    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // A request is taken whenever the result register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  swbl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_data_i),
    .cfg_i    (cfg_q),
    .rslt_o   (rslt)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= rslt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An acknowledged frame leaves the wire driven high and the sequencer idle.
  a_ack_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.acked |->
      out_data_o.line_mode == MODE_HIGH && !out_data_o.busy_res)
    else $error("acknowledge without high drive and idle");

endmodule
